// File: hdl/dotp_pkg.sv
package dotp_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [2:0] status_t;

	localparam kind_t K_ENQUEUE = 2'd0;
	localparam kind_t K_REMOVE  = 2'd1;
	localparam kind_t K_RESCHED = 2'd2;
	localparam kind_t K_CLAIM   = 2'd3;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_DUP      = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_NOTFOUND = 3'd3;
	localparam status_t ST_EMPTY    = 3'd4;

	localparam int DEF_CAPACITY = 16;
	localparam int DEF_ID_BITS  = 8;
	localparam int DEF_KEY_BITS = 32;

endpackage

// File: hdl/deadline_ordered_task_picker.sv
// channel | valid     | ready     | fields
// input   | in_valid  | in_ready  | kind, task_id, priority_req
// result  | res_valid | res_ready | status, out_task, out_valid, queued_count
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Enqueue/remove scan the table once through its single read port,
// then shift entries one per cycle as needed.
// A result waits in the output register until res_ready; the sequencer stalls there.
// arst_n clears count, next-task slot and control; table contents are not cleared.
module deadline_ordered_task_picker
	import dotp_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ID_BITS  = DEF_ID_BITS,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  task_id,
	input  logic [31:0] priority_req,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  status,
	output logic [7:0]  out_task,
	output logic        out_valid,
	output logic [4:0]  queued_count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_RS_TAKE = 3'd2;
	localparam logic [2:0] S_SHIFT   = 3'd3;
	localparam logic [2:0] S_INSERT  = 3'd4;
	localparam logic [2:0] S_RESULT  = 3'd5;

	logic [ID_BITS-1:0]  task_mem [CAPACITY];
	logic [KEY_BITS-1:0] key_mem  [CAPACITY];
	logic [ID_BITS-1:0]  rd_task_q;
	logic [KEY_BITS-1:0] rd_key_q;

	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ID_BITS-1:0]  wr_task;
	logic [KEY_BITS-1:0] wr_key;

	logic [2:0]          state_q;
	kind_t               kind_q;
	logic [ID_BITS-1:0]  id_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    count_q;
	logic                chosen_valid_q;
	logic [ID_BITS-1:0]  chosen_task_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                rpend_q;
	logic [IDX_W-1:0]    ridx_q;
	logic                found_q;
	logic [IDX_W-1:0]    found_idx_q;
	logic                gt_q;
	logic [IDX_W-1:0]    pos_q;
	logic                up_q;
	logic                iss_q;
	logic                spend_q;
	logic [IDX_W-1:0]    src_q;
	logic [IDX_W-1:0]    end_q;
	logic [IDX_W-1:0]    dst_q;
	status_t             st_q;
	logic [ID_BITS-1:0]  otask_q;
	logic                ovalid_q;
	logic                res_valid_q;
	status_t             status_q;
	logic [7:0]          out_task_q;
	logic                out_valid_q;
	logic [4:0]          queued_count_q;

	logic in_fire;
	logic scan_more;

	assign in_ready     = (state_q == S_IDLE);
	assign in_fire      = in_valid && in_ready;
	assign scan_more    = (scan_idx_q < count_q);
	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign out_task     = out_task_q;
	assign out_valid    = out_valid_q;
	assign queued_count = queued_count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			task_mem[wr_addr] <= wr_task;
			key_mem[wr_addr]  <= wr_key;
		end
		rd_task_q <= task_mem[rd_addr];
		rd_key_q  <= key_mem[rd_addr];
	end

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = dst_q;
		wr_task = rd_task_q;
		wr_key  = rd_key_q;
		unique case (state_q)
			S_SCAN: begin
				rd_addr = scan_idx_q[IDX_W-1:0];
			end
			S_SHIFT: begin
				rd_addr = src_q;
				wr_en   = spend_q;
			end
			S_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_task = id_q;
				wr_key  = key_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			kind_q         <= K_ENQUEUE;
			id_q           <= '0;
			key_q          <= '0;
			count_q        <= '0;
			chosen_valid_q <= 1'b0;
			chosen_task_q  <= '0;
			scan_idx_q     <= '0;
			rpend_q        <= 1'b0;
			ridx_q         <= '0;
			found_q        <= 1'b0;
			found_idx_q    <= '0;
			gt_q           <= 1'b0;
			pos_q          <= '0;
			up_q           <= 1'b0;
			iss_q          <= 1'b0;
			spend_q        <= 1'b0;
			src_q          <= '0;
			end_q          <= '0;
			dst_q          <= '0;
			st_q           <= ST_OK;
			otask_q        <= '0;
			ovalid_q       <= 1'b0;
			res_valid_q    <= 1'b0;
			status_q       <= ST_OK;
			out_task_q     <= '0;
			out_valid_q    <= 1'b0;
			queued_count_q <= '0;
		end else begin
			if (res_ready && (state_q != S_RESULT)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						kind_q     <= kind;
						id_q       <= ID_BITS'(task_id);
						key_q      <= KEY_BITS'(priority_req);
						found_q    <= 1'b0;
						gt_q       <= 1'b0;
						scan_idx_q <= '0;
						rpend_q    <= 1'b0;
						otask_q    <= '0;
						ovalid_q   <= 1'b0;
						st_q       <= ST_OK;
						unique case (kind)
							K_ENQUEUE, K_REMOVE: begin
								state_q <= S_SCAN;
							end
							K_RESCHED: begin
								if (chosen_valid_q) begin
									state_q <= S_RESULT;
								end else if (count_q == '0) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESULT;
								end else begin
									state_q <= S_RS_TAKE;
								end
							end
							K_CLAIM: begin
								if (chosen_valid_q) begin
									otask_q        <= chosen_task_q;
									ovalid_q       <= 1'b1;
									chosen_valid_q <= 1'b0;
									chosen_task_q  <= '0;
								end
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
						rpend_q    <= 1'b1;
						ridx_q     <= scan_idx_q[IDX_W-1:0];
					end else begin
						rpend_q <= 1'b0;
					end
					if (rpend_q) begin
						if (rd_task_q == id_q) begin
							found_q     <= 1'b1;
							found_idx_q <= ridx_q;
						end
						if (!gt_q && (rd_key_q > key_q)) begin
							gt_q  <= 1'b1;
							pos_q <= ridx_q;
						end
					end
					if (!scan_more && !rpend_q) begin
						if (kind_q == K_ENQUEUE) begin
							if (found_q) begin
								st_q    <= ST_DUP;
								state_q <= S_RESULT;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								st_q    <= ST_FULL;
								state_q <= S_RESULT;
							end else if (gt_q) begin
								up_q    <= 1'b1;
								iss_q   <= 1'b1;
								spend_q <= 1'b0;
								src_q   <= IDX_W'(count_q - CNT_W'(1));
								end_q   <= pos_q;
								state_q <= S_SHIFT;
							end else begin
								pos_q   <= IDX_W'(count_q);
								state_q <= S_INSERT;
							end
						end else begin
							if (!found_q) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_RESULT;
							end else if ((CNT_W'(found_idx_q) + CNT_W'(1)) < count_q) begin
								up_q    <= 1'b0;
								iss_q   <= 1'b1;
								spend_q <= 1'b0;
								src_q   <= found_idx_q + IDX_W'(1);
								end_q   <= IDX_W'(count_q - CNT_W'(1));
								state_q <= S_SHIFT;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_RESULT;
							end
						end
					end
				end
				S_RS_TAKE: begin
					chosen_task_q  <= rd_task_q;
					chosen_valid_q <= 1'b1;
					if (count_q > CNT_W'(1)) begin
						up_q    <= 1'b0;
						iss_q   <= 1'b1;
						spend_q <= 1'b0;
						src_q   <= IDX_W'(1);
						end_q   <= IDX_W'(count_q - CNT_W'(1));
						state_q <= S_SHIFT;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_RESULT;
					end
				end
				S_SHIFT: begin
					if (iss_q) begin
						spend_q <= 1'b1;
						dst_q   <= up_q ? (src_q + IDX_W'(1)) : (src_q - IDX_W'(1));
						if (src_q == end_q) begin
							iss_q <= 1'b0;
						end else begin
							src_q <= up_q ? (src_q - IDX_W'(1)) : (src_q + IDX_W'(1));
						end
					end else begin
						spend_q <= 1'b0;
						if (spend_q) begin
							if (up_q) begin
								state_q <= S_INSERT;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_RESULT;
							end
						end
					end
				end
				S_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q    <= 1'b1;
						status_q       <= st_q;
						out_task_q     <= 8'(otask_q);
						out_valid_q    <= ovalid_q;
						queued_count_q <= 5'(count_q);
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("table count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ((count_q == $past(count_q) + CNT_W'(1)) ||
			(count_q + CNT_W'(1) == $past(count_q))))
		else $error("table count moved by more than one");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |-> ((count_q < CNT_W'(CAPACITY)) &&
			(CNT_W'(pos_q) <= count_q)))
		else $error("insert into full table or beyond its end");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CNT_W'(wr_addr) <= count_q))
		else $error("table write beyond occupied range");

	a_claim_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (kind == K_CLAIM)) |=> !chosen_valid_q)
		else $error("next-task slot not cleared by claim");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_RESULT))
		else $error("result raised outside result state");
`endif

endmodule

// File: test/deadline_ordered_task_picker_test.sv
`timescale 1ns / 100ps

module deadline_ordered_task_picker_test;
	import dotp_pkg::*;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int CYCLE_CAP  = 600000;
	localparam int DRAIN_WAIT = 60;
	localparam int HOLD_LEN   = 400;
	localparam int PHASE_LEN  = 250;

	typedef struct packed {
		status_t    st;
		logic [7:0] tid;
		logic       tvalid;
		logic [4:0] count;
	} outcome_t;

	typedef struct {
		logic [7:0]  id;
		logic [31:0] key;
	} waiting_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  id;
		logic [31:0] key;
		bit          typed;
		outcome_t    want;
	} row_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	kind_t       kind         = K_ENQUEUE;
	logic [7:0]  task_id      = 8'd0;
	logic [31:0] priority_req = 32'd0;
	logic        res_valid;
	logic        res_ready    = 1'b0;
	status_t     status;
	logic [7:0]  out_task;
	logic        out_valid;
	logic [4:0]  queued_count;

	waiting_t    waiting_tasks[$];
	logic        next_valid = 1'b0;
	logic [7:0]  next_task  = 8'd0;
	outcome_t    outcomes_due[$];
	row_t        directed_rows[$];

	int          mismatches   = 0;
	int          cycle_count  = 0;
	int          sender_idle  = 0;
	int          recv_stall   = 0;
	bit          hold_request = 1'b0;

	deadline_ordered_task_picker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.task_id      (task_id),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.out_task     (out_task),
		.out_valid    (out_valid),
		.queued_count (queued_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic outcome_t outcome_of(kind_t k, logic [7:0] id, logic [31:0] key);
		outcome_t o;
		waiting_t e;
		int pos;
		int hit;
		o = '0;
		o.st = ST_OK;
		hit = -1;
		for (int i = 0; i < waiting_tasks.size(); i++) begin
			if (hit < 0 && waiting_tasks[i].id == id)
				hit = i;
		end
		case (k)
			K_ENQUEUE: begin
				if (hit >= 0) begin
					o.st = ST_DUP;
				end else if (waiting_tasks.size() >= CAPACITY) begin
					o.st = ST_FULL;
				end else begin
					pos = waiting_tasks.size();
					for (int i = waiting_tasks.size() - 1; i >= 0; i--) begin
						if (waiting_tasks[i].key > key)
							pos = i;
					end
					e.id = id;
					e.key = key;
					waiting_tasks.insert(pos, e);
				end
			end
			K_REMOVE: begin
				if (hit < 0)
					o.st = ST_NOTFOUND;
				else
					waiting_tasks.delete(hit);
			end
			K_RESCHED: begin
				if (!next_valid) begin
					if (waiting_tasks.size() == 0) begin
						o.st = ST_EMPTY;
					end else begin
						next_task = waiting_tasks[0].id;
						next_valid = 1'b1;
						waiting_tasks.delete(0);
					end
				end
			end
			default: begin
				if (next_valid) begin
					o.tid = next_task;
					o.tvalid = 1'b1;
					next_valid = 1'b0;
					next_task = 8'd0;
				end
			end
		endcase
		o.count = 5'(waiting_tasks.size());
		return o;
	endfunction

	task automatic add_row(kind_t k, logic [7:0] id, logic [31:0] key, bit typed,
			status_t st, logic [7:0] tid, logic tv, logic [4:0] cnt);
		row_t r;
		r.kind = k;
		r.id = id;
		r.key = key;
		r.typed = typed;
		r.want.st = st;
		r.want.tid = tid;
		r.want.tvalid = tv;
		r.want.count = cnt;
		directed_rows.push_back(r);
	endtask

	// called right after a falling edge, returns right after one
	task automatic send_item(kind_t k, logic [7:0] id, logic [31:0] key, bit typed,
			outcome_t want);
		outcome_t got;
		while ($urandom_range(0, 99) < sender_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		task_id <= id;
		priority_req <= key;
		do @(posedge clk); while (!in_ready);
		got = outcome_of(k, id, key);
		outcomes_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic pick_item(int n, output kind_t k, output logic [7:0] id,
			output logic [31:0] key);
		int r;
		bit fill;
		fill = ((n / 50) % 2) == 0;
		r = $urandom_range(0, 99);
		if (fill)
			k = (r < 65) ? K_ENQUEUE : (r < 75) ? K_REMOVE : (r < 88) ? K_RESCHED : K_CLAIM;
		else
			k = (r < 25) ? K_ENQUEUE : (r < 45) ? K_REMOVE : (r < 75) ? K_RESCHED : K_CLAIM;
		if ($urandom_range(0, 99) < 60)
			id = 8'($urandom_range(0, 23));
		else
			id = 8'($urandom_range(0, 255));
		if (k == K_REMOVE && waiting_tasks.size() > 0 && $urandom_range(0, 99) < 75)
			id = waiting_tasks[$urandom_range(0, waiting_tasks.size() - 1)].id;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: key = 32'($urandom_range(0, 7));
			4, 5, 6:    key = $urandom();
			7:          key = 32'd0;
			8:          key = 32'hFFFF_FFFF;
			default:    key = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
		endcase
	endtask

	task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && res_valid && res_ready) begin
			if (outcomes_due.size() == 0) begin
				$error("result with no item pending");
				mismatches++;
			end else begin
				want = outcomes_due.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("out_task", 32'(want.tid), 32'(out_task));
				check_field("out_valid", 32'(want.tvalid), 32'(out_valid));
				check_field("queued_count", 32'(want.count), 32'(queued_count));
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				res_ready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
				hold_request = 1'b0;
			end
			res_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	initial begin
		kind_t       k;
		logic [7:0]  id;
		logic [31:0] key;
		outcome_t    none;
		none = '0;

		add_row(K_CLAIM,   8'hA5, 32'd0,        1'b1, ST_OK,       8'd0, 1'b0, 5'd0);
		add_row(K_RESCHED, 8'h5A, 32'd0,        1'b1, ST_EMPTY,    8'd0, 1'b0, 5'd0);
		add_row(K_REMOVE,  8'h00, 32'd0,        1'b1, ST_NOTFOUND, 8'd0, 1'b0, 5'd0);
		add_row(K_ENQUEUE, 8'h00, 32'hFFFF_FFFF, 1'b1, ST_OK,      8'd0, 1'b0, 5'd1);
		add_row(K_ENQUEUE, 8'h00, 32'd3,        1'b1, ST_DUP,      8'd0, 1'b0, 5'd1);
		add_row(K_ENQUEUE, 8'hFF, 32'd0,        1'b1, ST_OK,       8'd0, 1'b0, 5'd2);
		add_row(K_ENQUEUE, 8'h05, 32'd0,        1'b1, ST_OK,       8'd0, 1'b0, 5'd3);
		add_row(K_RESCHED, 8'hA5, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);
		add_row(K_RESCHED, 8'hA5, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);
		// id held only in the next-task slot may be queued again
		add_row(K_ENQUEUE, 8'hFF, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);
		add_row(K_CLAIM,   8'h5A, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);
		add_row(K_REMOVE,  8'h05, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);
		for (int i = 0; i < CAPACITY - 2; i++)
			add_row(K_ENQUEUE, 8'(8'h10 + i), 32'((i % 3) * 7), 1'b1, ST_OK, 8'd0, 1'b0,
				5'(3 + i));
		add_row(K_ENQUEUE, 8'hAA, 32'd1,        1'b1, ST_FULL,     8'd0, 1'b0, 5'(CAPACITY));
		// duplicate wins over full
		add_row(K_ENQUEUE, 8'h00, 32'd1,        1'b1, ST_DUP,      8'd0, 1'b0, 5'(CAPACITY));
		add_row(K_RESCHED, 8'hA5, 32'd0,        1'b0, ST_OK,       8'd0, 1'b0, 5'd0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].kind, directed_rows[i].id, directed_rows[i].key,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin sender_idle = 0;  recv_stall = 0;  end
				1: begin sender_idle = 80; recv_stall = 0;  end
				2: begin sender_idle = 0;  recv_stall = 80; end
				3: begin sender_idle = 29; recv_stall = 29; end
				default: begin
					sender_idle = 0;
					recv_stall = 0;
					hold_request = 1'b1;
				end
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				pick_item(n, k, id, key);
				send_item(k, id, key, 1'b0, none);
			end
		end
		in_valid <= 1'b0;

		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
